// ----- rtl/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int PATTERN_MAX_DEF = 63;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_END    = 2'd3
    } req_type_t;

    // Broadcast control from the top level to every cell of the row
    typedef struct packed {
        logic       restart;   // reseed the active set with position zero
        logic       advance;   // step the active set over one text byte
        logic       append;    // store a pattern byte (room is known to exist)
        logic [7:0] char_byte; // text or pattern byte of the request
    } cell_ctrl_t;

endpackage

// ----- rtl/wildcard_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Streams text bytes against a stored pattern with '*' and '?' wildcards.
// ----------------------------------------------------------------------------
// Requests carry a kind in tuser (clear pattern, append pattern byte, text
// byte, end of text) and a byte in tdata. The block takes one request per
// clock cycle while no waiting result is stalled. Each request for end of
// text yields one result, registered and shown in the cycle after its
// acceptance: bit 0 says whether the whole text matched, bit 1 whether pattern
// bytes were dropped because more than PATTERN_MAX were appended since the
// last clear. Every pattern position is a cell of a row; a text byte updates
// all of them in the same cycle, and the longest path is the star closure
// rippling through the PATTERN_MAX+1 cells, which sets the clock rate. A waiting
// result holds input acceptance only while the downstream side is not ready.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             first_star_reg, first_star_next;
    logic             ovf_reg, ovf_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_match_reg, out_match_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             accept;
    req_type_t        req;
    logic             room;
    cell_ctrl_t       ctrl;

    logic             carry [0:PATTERN_MAX+1];
    logic             step  [0:PATTERN_MAX+1];
    logic             closed [0:PATTERN_MAX];

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign req           = req_type_t'(s_axis_tuser);
    assign room          = len_reg < LEN_W'(PATTERN_MAX);

    assign ctrl.restart   = accept && (req != REQ_TEXT);
    assign ctrl.advance   = accept && (req == REQ_TEXT);
    assign ctrl.append    = accept && (req == REQ_APPEND) && room;
    assign ctrl.char_byte = s_axis_tdata;

    assign carry[0] = 1'b0;
    assign step[0]  = 1'b0;

    for (genvar i = 0; i <= PATTERN_MAX; i++)
    begin : g_cell
        wgm_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .pat_len   (len_reg),
            .carry_in  (carry[i]),
            .step_in   (step[i]),
            .carry_out (carry[i+1]),
            .step_out  (step[i+1]),
            .closed    (closed[i])
        );
    end

    always_comb
    begin
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        first_star_next = first_star_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg & ~m_axis_tready;
        out_match_next  = out_match_reg;
        out_ovf_next    = out_ovf_reg;
        if (accept)
        begin
            case (req)
                REQ_CLEAR:
                begin
                    len_next        = '0;
                    ovf_next        = 1'b0;
                    cnt_next        = 2'd0;
                    first_star_next = 1'b0;
                end
                REQ_APPEND:
                begin
                    if (room)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_next        = 2'd0;
                    first_star_next = 1'b0;
                end
                REQ_TEXT:
                begin
                    if (cnt_reg == 2'd0)
                    begin
                        first_star_next = s_axis_tdata == CH_STAR;
                    end
                    if (cnt_reg != 2'd2)
                    begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                REQ_END:
                begin
                    // a text of one single star matches any pattern
                    out_valid_next  = 1'b1;
                    out_match_next  = closed[len_reg] | (cnt_reg == 2'd1 && first_star_reg);
                    out_ovf_next    = ovf_reg;
                    cnt_next        = 2'd0;
                    first_star_next = 1'b0;
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            cnt_reg        <= 2'd0;
            first_star_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            cnt_reg        <= cnt_next;
            first_star_reg <= first_star_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_match_reg <= out_match_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_ovf_reg, out_match_reg};

endmodule

// ----- rtl/wgm_cell.sv -----
// ----------------------------------------------------------------------------
// wgm_cell
// One pattern position: holds its pattern byte and the raw active bit, and
// ripples star closure and byte matches on to the next position.
// ----------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [LEN_W-1:0] pat_len,
    input  logic             carry_in,  // closed active bit of the previous star
    input  logic             step_in,   // previous position matched the text byte
    output logic             carry_out,
    output logic             step_out,
    output logic             closed     // active bit after star closure
);

    logic [7:0] pat_reg;
    logic       raw_reg;
    logic       raw_next;
    logic       used;
    logic       is_star;
    logic       hit;

    assign used    = pat_len > LEN_W'(IDX);
    assign is_star = pat_reg == CH_STAR;
    assign hit     = (pat_reg == CH_QMARK) || (pat_reg == ctrl.char_byte);

    assign closed    = raw_reg | carry_in;
    assign carry_out = closed & used & is_star;
    assign step_out  = closed & used & ~is_star & hit;

    always_comb
    begin
        raw_next = raw_reg;
        if (ctrl.restart)
        begin
            raw_next = (IDX == 0);
        end
        else if (ctrl.advance)
        begin
            // a star keeps its own position, a match moves up by one
            raw_next = (closed & used & is_star) | step_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg <= (IDX == 0);
        end
        else
        begin
            raw_reg <= raw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.append && pat_len == LEN_W'(IDX))
        begin
            pat_reg <= ctrl.char_byte;
        end
    end

endmodule

// ----- rtl/wgm_checker.sv -----
// ----------------------------------------------------------------------------
// wgm_checker
// Port-level checks for the wildcard glob matcher.
// ----------------------------------------------------------------------------
module wgm_checker
    import wgm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an end-of-text request always yields a result in the next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_END |=> m_axis_tvalid)
        else $error("end of text gave no result");

    // only a result blocked downstream may hold back requests
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request side stalled without a waiting result");

    // a fresh result comes only from an end-of-text request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_END)
        && !(m_axis_tvalid && !m_axis_tready) |=> !m_axis_tvalid)
        else $error("result without end of text");

    // overflow is cleared by a clear request and cannot show right after one
    a_clear_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_CLEAR
        ##1 s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_END
        |=> !m_axis_tdata[1])
        else $error("overflow survived a clear");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
